// ===== hdl/ssq_pkg.sv =====
// Shared constants, types and helpers for the sorted sleep queue.
package ssq_pkg;

  localparam int MAX_SLEEPERS = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int TICK_W       = 32;
  localparam int ID_W         = 8;
  localparam int MS_W         = 32;
  localparam int RATE_W       = 20;
  localparam int CNT_OUT_W    = 5;
  localparam int RATE_RESET   = 1000;
  localparam int MS_PER_S     = 1000;

  localparam int PROD_W    = MS_W + RATE_W;
  localparam int IDX_W     = $clog2(MAX_SLEEPERS);
  localparam int CNT_W     = $clog2(MAX_SLEEPERS + 1);
  localparam int WCNT_W    = $clog2(RESULT_LIMIT + 1);
  localparam int REM_W     = $clog2(MS_PER_S);
  localparam int DIV_STEPS = 4;
  localparam int DIV_ITERS = PROD_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  typedef enum logic {
    FUNC_SLEEP = 1'b0,
    FUNC_WAKE  = 1'b1
  } ssq_func_t;

  typedef enum logic {
    KIND_ACK   = 1'b0,
    KIND_WOKEN = 1'b1
  } ssq_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_YIELD   = 2'd1,
    ST_FULL    = 2'd2,
    ST_REFUSED = 2'd3
  } ssq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_ADD,
    S_SEARCH,
    S_INSERT,
    S_ACK,
    S_WAKE
  } ssq_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic calc_tgt;
    logic srch_step;
    logic insert;
    logic ack;
    logic pop;
  } ssq_cmd_t;

  typedef struct packed {
    logic is_wake;
    logic reject;
    logic div_done;
    logic srch_hit;
    logic head_due;
    logic pop_last;
    logic out_free;
  } ssq_stat_t;

  function automatic logic [CNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+CNT_OUT_W-1:0] ext;
    ext = {{CNT_OUT_W{1'b0}}, cnt};
    return ext[CNT_OUT_W-1:0];
  endfunction

endpackage

// ===== hdl/sorted_sleep_queue_wakeup_core.sv =====
// Top level of the sorted sleep queue: controller and datapath.
// Sleep request: a rejected word goes straight from dispatch to its result; a queued task first
// passes through the divide by 1000 and the one-entry-per-cycle position search.
// Wakeup check: one woken task per cycle while the output register is free.
// One word at a time; the next word is taken as soon as the last result sits in the output register.
// Synchronous active-low reset empties the queue and sets the tick rate to 1000.
module sorted_sleep_queue_wakeup_core
  import ssq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [RATE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [ID_W-1:0]      in_task_id,
  input  logic [MS_W-1:0]      in_duration_ms,
  input  logic [TICK_W-1:0]    in_now_tick,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [ID_W-1:0]      out_woken_or_queued_id,
  output logic [1:0]           out_status,
  output logic [CNT_OUT_W-1:0] out_sleeping_count,
  output logic                 out_last
);

  ssq_cmd_t  cmd;
  ssq_stat_t st;

  ssq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ssq_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .st                     (st),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_func                (in_func),
    .in_task_id             (in_task_id),
    .in_duration_ms         (in_duration_ms),
    .in_now_tick            (in_now_tick),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_kind               (out_kind),
    .out_woken_or_queued_id (out_woken_or_queued_id),
    .out_status             (out_status),
    .out_sleeping_count     (out_sleeping_count),
    .out_last               (out_last)
  );

endmodule

// ===== hdl/ssq_div.sv =====
// Digit-serial divider of the tick product by the milliseconds per second.
module ssq_div
  import ssq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  output logic [PROD_W-1:0] quotient,
  output logic              done
);

  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [PROD_W-1:0]    quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  always_comb begin
    logic [REM_W:0] t;
    logic           ge;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int s = 0; s < DIV_STEPS; s++) begin
      t  = {rem_nxt, quo_nxt[PROD_W-1]};
      ge = (t >= (REM_W+1)'(MS_PER_S));
      rem_nxt = ge ? REM_W'(t - (REM_W+1)'(MS_PER_S)) : t[REM_W-1:0];
      quo_nxt = {quo_nxt[PROD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= DIV_CNT_W'(cnt_r + 1'b1);
      if (cnt_r == DIV_CNT_W'(DIV_ITERS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== hdl/ssq_dp.sv =====
// Datapath: rate register, tick conversion, sorted store and result register.
module ssq_dp
  import ssq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssq_cmd_t             cmd,
  output ssq_stat_t            st,
  input  logic                 cfg_we,
  input  logic [RATE_W-1:0]    cfg_wdata,
  input  logic                 in_func,
  input  logic [ID_W-1:0]      in_task_id,
  input  logic [MS_W-1:0]      in_duration_ms,
  input  logic [TICK_W-1:0]    in_now_tick,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [ID_W-1:0]      out_woken_or_queued_id,
  output logic [1:0]           out_status,
  output logic [CNT_OUT_W-1:0] out_sleeping_count,
  output logic                 out_last
);

  logic [RATE_W-1:0] tps_r;
  logic              func_r;
  logic [ID_W-1:0]   id_r;
  logic [TICK_W-1:0] now_r;
  ssq_status_t       status_r, status_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [TICK_W-1:0] tgt_r, tgt_nxt;
  logic [CNT_W-1:0]  srch_r;
  logic [CNT_W-1:0]  occ_r;
  logic [WCNT_W-1:0] wcnt_r;

  logic [TICK_W-1:0] ticks_r [MAX_SLEEPERS];
  logic [ID_W-1:0]   ids_r   [MAX_SLEEPERS];

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [ID_W-1:0]      out_id_r;
  logic [1:0]           out_status_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic                 out_last_r;

  logic [PROD_W-1:0] quo;
  logic              div_done;
  logic [PROD_W-1:0] quo_adj;
  logic [PROD_W:0]   sum;
  logic [TICK_W-1:0] srch_tick;
  logic              head_due;
  logic              next_due;
  logic              out_free;

  ssq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .quotient (quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= RATE_W'(RATE_RESET);
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (in_duration_ms == '0) begin
      status_nxt = ST_YIELD;
    end else if (in_task_id == '0) begin
      status_nxt = ST_REFUSED;
    end else if (occ_r >= CNT_W'(MAX_SLEEPERS)) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      id_r     <= in_task_id;
      now_r    <= in_now_tick;
      status_r <= status_nxt;
      prod_r   <= PROD_W'(in_duration_ms) * PROD_W'(tps_r);
    end
  end

  assign quo_adj = (quo == '0) ? PROD_W'(1) : quo;
  assign sum     = {1'b0, quo_adj} + (PROD_W+1)'(now_r);
  assign tgt_nxt = (|sum[PROD_W:TICK_W]) ? '1 : sum[TICK_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.calc_tgt) begin
      tgt_r <= tgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_tgt) begin
      srch_r <= '0;
    end else if (cmd.srch_step) begin
      srch_r <= CNT_W'(srch_r + 1'b1);
    end
  end

  assign srch_tick = ticks_r[srch_r[IDX_W-1:0]];

  always_comb begin
    if (srch_r == occ_r) begin
      st.srch_hit = 1'b1;
    end else if (srch_r == '0) begin
      st.srch_hit = (tgt_r <= srch_tick);
    end else begin
      st.srch_hit = (srch_tick > tgt_r);
    end
  end

  for (genvar j = 0; j < MAX_SLEEPERS; j++) begin : g_entry
    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (CNT_W'(j) == srch_r) begin
          ticks_r[j] <= tgt_r;
          ids_r[j]   <= id_r;
        end else if (CNT_W'(j) > srch_r && CNT_W'(j) <= occ_r) begin
          ticks_r[j] <= ticks_r[(j + MAX_SLEEPERS - 1) % MAX_SLEEPERS];
          ids_r[j]   <= ids_r[(j + MAX_SLEEPERS - 1) % MAX_SLEEPERS];
        end
      end else if (cmd.pop && j < MAX_SLEEPERS - 1) begin
        ticks_r[j] <= ticks_r[(j + 1) % MAX_SLEEPERS];
        ids_r[j]   <= ids_r[(j + 1) % MAX_SLEEPERS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.insert) begin
      occ_r <= CNT_W'(occ_r + 1'b1);
    end else if (cmd.pop) begin
      occ_r <= CNT_W'(occ_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wcnt_r <= '0;
    end else if (cmd.pop) begin
      wcnt_r <= WCNT_W'(wcnt_r + 1'b1);
    end
  end

  assign head_due = (occ_r != '0) && (wcnt_r < WCNT_W'(RESULT_LIMIT)) &&
                    (ticks_r[0] <= now_r);
  assign next_due = (occ_r >= CNT_W'(2)) &&
                    (WCNT_W'(wcnt_r + 1'b1) < WCNT_W'(RESULT_LIMIT)) &&
                    (ticks_r[1] <= now_r);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ack || cmd.pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ack) begin
      out_kind_r   <= KIND_ACK;
      out_id_r     <= id_r;
      out_status_r <= status_r;
      out_count_r  <= count_out(occ_r);
      out_last_r   <= 1'b1;
    end else if (cmd.pop) begin
      out_kind_r   <= KIND_WOKEN;
      out_id_r     <= ids_r[0];
      out_status_r <= ST_OK;
      out_count_r  <= count_out(CNT_W'(occ_r - 1'b1));
      out_last_r   <= !next_due;
    end
  end

  assign st.is_wake  = (func_r == FUNC_WAKE);
  assign st.reject   = (status_r != ST_OK);
  assign st.div_done = div_done;
  assign st.head_due = head_due;
  assign st.pop_last = !next_due;
  assign st.out_free = out_free;

  assign out_valid              = out_valid_r;
  assign out_kind               = out_kind_r;
  assign out_woken_or_queued_id = out_id_r;
  assign out_status             = out_status_r;
  assign out_sleeping_count     = out_count_r;
  assign out_last               = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(MAX_SLEEPERS))
    else $error("occupancy above store depth");

  a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> head_due && out_free)
    else $error("pop without a due head or a free result register");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> occ_r == CNT_W'($past(occ_r) + 1'b1))
    else $error("insert did not grow the store by one");

endmodule

// ===== hdl/ssq_ctrl.sv =====
// Controller state machine sequencing sleep inserts and wakeup drains.
module ssq_ctrl
  import ssq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ssq_stat_t st,
  output ssq_cmd_t  cmd
);

  ssq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        priority if (st.is_wake) state_nxt = S_WAKE;
        else if (st.reject)      state_nxt = S_ACK;
        else                     state_nxt = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) state_nxt = S_ADD;
      end
      S_ADD: begin
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (st.srch_hit) state_nxt = S_INSERT;
      end
      S_INSERT: begin
        state_nxt = S_ACK;
      end
      S_ACK: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      S_WAKE: begin
        priority if (!st.head_due)            state_nxt = S_IDLE;
        else if (st.out_free && st.pop_last)  state_nxt = S_IDLE;
        else                                  state_nxt = S_WAKE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        cmd.div_start = !st.is_wake && !st.reject;
      end
      S_DIV: begin
      end
      S_ADD: begin
        cmd.calc_tgt = 1'b1;
      end
      S_SEARCH: begin
        cmd.srch_step = !st.srch_hit;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
      end
      S_ACK: begin
        cmd.ack = st.out_free;
      end
      S_WAKE: begin
        cmd.pop = st.head_due && st.out_free;
      end
      default: begin
      end
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert || cmd.pop || cmd.ack) |-> !in_ready)
    else $error("store or result update while taking a new word");

  a_insert_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> $past(state_r == S_SEARCH && st.srch_hit))
    else $error("insert without a finished search");

endmodule

// ===== sim/sorted_sleep_queue_wakeup_core_test.sv =====
// Self-checking testbench for the sorted sleep queue: directed table, random words, tick rates.
`timescale 1ns / 100ps

module sorted_sleep_queue_wakeup_core_test;
  import ssq_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 400;
  localparam int DIR_ROWS      = 25;
  localparam logic [TICK_W-1:0] TICK_TOP = '1;

  typedef struct packed {
    ssq_func_t             func;
    logic [ID_W-1:0]       task_id;
    logic [MS_W-1:0]       ms;
    logic [TICK_W-1:0]     now;
    logic                  typed;
    ssq_status_t           status;
    logic [CNT_OUT_W-1:0]  count;
  } stim_row_t;

  typedef struct packed {
    ssq_kind_t             kind;
    logic [ID_W-1:0]       id;
    ssq_status_t           status;
    logic [CNT_OUT_W-1:0]  count;
    logic                  last;
  } sleep_report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [RATE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_func = FUNC_SLEEP;
  logic [ID_W-1:0]      in_task_id = '0;
  logic [MS_W-1:0]      in_duration_ms = '0;
  logic [TICK_W-1:0]    in_now_tick = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_kind;
  logic [ID_W-1:0]      out_woken_or_queued_id;
  logic [1:0]           out_status;
  logic [CNT_OUT_W-1:0] out_sleeping_count;
  logic                 out_last;

  logic [TICK_W-1:0] sleep_ticks [MAX_SLEEPERS];
  logic [ID_W-1:0]   sleep_ids [MAX_SLEEPERS];
  int                sleep_count = 0;
  logic [RATE_W-1:0] tick_rate = RATE_RESET;

  sleep_report_t awaited_reports [$];
  int            fail_count = 0;
  int            cycle_count = 0;
  bit            tx_calm = 1'b0;

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{FUNC_WAKE,  8'd0,   32'd0,          32'd0,          1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'd5,   32'd0,          32'd0,          1'b1, ST_YIELD,   5'd0},
    '{FUNC_SLEEP, 8'd0,   32'd10,         32'd0,          1'b1, ST_REFUSED, 5'd0},
    '{FUNC_SLEEP, 8'd255, 32'd10,         32'd100,        1'b1, ST_OK,      5'd1},
    '{FUNC_SLEEP, 8'd7,   32'd10,         32'd100,        1'b1, ST_OK,      5'd2},
    '{FUNC_SLEEP, 8'd8,   32'd20,         32'd100,        1'b1, ST_OK,      5'd3},
    '{FUNC_SLEEP, 8'd9,   32'd10,         32'd100,        1'b1, ST_OK,      5'd4},
    '{FUNC_SLEEP, 8'd10,  32'd15,         32'd100,        1'b1, ST_OK,      5'd5},
    '{FUNC_SLEEP, 8'd11,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, ST_OK,      5'd6},
    '{FUNC_SLEEP, 8'd12,  32'd1,          32'hFFFF_FFFE,  1'b1, ST_OK,      5'd7},
    '{FUNC_SLEEP, 8'd13,  32'hFFFF_FFFF,  32'd0,          1'b1, ST_OK,      5'd8},
    '{FUNC_WAKE,  8'd0,   32'd0,          32'd110,        1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'hAA,  32'd1,          32'd200,        1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'h55,  32'h8000_0000,  32'd200,        1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'hF0,  32'd3,          32'd199,        1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'h0F,  32'd2,          32'd200,        1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'h01,  32'h7FFF_FFFF,  32'd1,          1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'h80,  32'd1,          32'd0,          1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'hFE,  32'd5,          32'd115,        1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'h7F,  32'd1,          32'd114,        1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'h33,  32'd1000,       32'd0,          1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'hCC,  32'h0001_0000,  32'hFFFF_0000,  1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'h99,  32'hFFFF_FFFE,  32'd1,          1'b0, ST_OK,      5'd0},
    '{FUNC_SLEEP, 8'h42,  32'd5,          32'd0,          1'b1, ST_FULL,    5'd16},
    '{FUNC_WAKE,  8'hFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, ST_OK,      5'd0}
  };

  sorted_sleep_queue_wakeup_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_func                (in_func),
    .in_task_id             (in_task_id),
    .in_duration_ms         (in_duration_ms),
    .in_now_tick            (in_now_tick),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_kind               (out_kind),
    .out_woken_or_queued_id (out_woken_or_queued_id),
    .out_status             (out_status),
    .out_sleeping_count     (out_sleeping_count),
    .out_last               (out_last)
  );

  always #10 clk = ~clk;

  function automatic sleep_report_t queue_sleeper(logic [ID_W-1:0] id, logic [MS_W-1:0] ms,
                                                  logic [TICK_W-1:0] now);
    logic [63:0]       ticks;
    logic [TICK_W-1:0] due;
    int                pos;
    ssq_status_t       status;
    if (ms == 0) begin
      status = ST_YIELD;
    end else if (id == 0) begin
      status = ST_REFUSED;
    end else if (sleep_count >= MAX_SLEEPERS) begin
      status = ST_FULL;
    end else begin
      ticks = (64'(ms) * 64'(tick_rate)) / 64'(MS_PER_S);
      if (ticks == 0) ticks = 64'd1;
      if (ticks > 64'(TICK_TOP) - 64'(now)) due = TICK_TOP;
      else due = TICK_W'(64'(now) + ticks);
      pos = 0;
      if (sleep_count > 0 && due > sleep_ticks[0]) begin
        pos = 1;
        while (pos < sleep_count && sleep_ticks[pos] <= due) pos++;
      end
      for (int i = sleep_count; i > pos; i--) begin
        sleep_ticks[i] = sleep_ticks[i-1];
        sleep_ids[i]   = sleep_ids[i-1];
      end
      sleep_ticks[pos] = due;
      sleep_ids[pos]   = id;
      sleep_count++;
      status = ST_OK;
    end
    return '{KIND_ACK, id, status, CNT_OUT_W'(sleep_count), 1'b1};
  endfunction

  function automatic void wake_due_sleepers(logic [TICK_W-1:0] now);
    int              woken;
    logic [ID_W-1:0] id;
    sleep_report_t   final_report;
    woken = 0;
    while (sleep_count > 0 && woken < RESULT_LIMIT && sleep_ticks[0] <= now) begin
      id = sleep_ids[0];
      for (int i = 1; i < sleep_count; i++) begin
        sleep_ticks[i-1] = sleep_ticks[i];
        sleep_ids[i-1]   = sleep_ids[i];
      end
      sleep_count--;
      awaited_reports.push_back('{KIND_WOKEN, id, ST_OK, CNT_OUT_W'(sleep_count), 1'b0});
      woken++;
    end
    if (woken > 0) begin
      final_report = awaited_reports.pop_back();
      final_report.last = 1'b1;
      awaited_reports.push_back(final_report);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_word(stim_row_t row);
    int unsigned   gap;
    sleep_report_t ack;
    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_func        <= row.func;
    in_task_id     <= row.task_id;
    in_duration_ms <= row.ms;
    in_now_tick    <= row.now;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (row.func == FUNC_SLEEP) begin
      ack = queue_sleeper(row.task_id, row.ms, row.now);
      if (row.typed) ack = '{KIND_ACK, row.task_id, row.status, row.count, 1'b1};
      awaited_reports.push_back(ack);
    end else begin
      wake_due_sleepers(row.now);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tick_rate(logic [RATE_W-1:0] rate);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(negedge clk);
    cfg_we <= 1'b0;
    tick_rate = rate;
  endtask

  task automatic run_random_words(int words, logic [TICK_W-1:0] start_tick);
    stim_row_t         row;
    int                pick;
    int                fill_left;
    logic [TICK_W-1:0] clock_tick;
    fill_left  = 0;
    clock_tick = start_tick;
    for (int k = 0; k < words; k++) begin
      row  = '0;
      pick = $urandom_range(0, 99);
      if (fill_left == 0 && pick < 6) fill_left = MAX_SLEEPERS + 2;
      if (fill_left > 0) begin
        fill_left--;
        row.func    = FUNC_SLEEP;
        row.task_id = $urandom_range(1, 255);
        row.ms      = $urandom_range(1, 60);
        row.now     = clock_tick;
      end else if (pick < 14) begin
        row.func = FUNC_SLEEP;
        if ($urandom_range(0, 1) == 1) begin
          row.ms      = '0;
          row.task_id = $urandom_range(0, 255);
        end else begin
          row.ms      = $urandom;
          row.task_id = '0;
        end
        row.now = $urandom;
      end else if (pick < 60) begin
        row.func    = FUNC_SLEEP;
        row.task_id = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 255);
        case ($urandom_range(0, 9))
          0: row.ms = $urandom;
          1: row.ms = '1;
          2, 3: row.ms = $urandom_range(1, 5000);
          default: row.ms = $urandom_range(1, 60);
        endcase
        row.now = ($urandom_range(0, 19) == 0) ? TICK_W'($urandom) : clock_tick;
      end else begin
        row.func    = FUNC_WAKE;
        row.task_id = $urandom_range(0, 255);
        row.ms      = $urandom;
        clock_tick  = clock_tick + $urandom_range(0, 40) * (tick_rate / MS_PER_S + 1);
        case ($urandom_range(0, 19))
          0: row.now = TICK_TOP;
          1: row.now = $urandom;
          default: row.now = clock_tick;
        endcase
      end
      send_word(row);
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < DIR_ROWS; r++) send_word(directed_rows[r]);
    wait_idle();
    set_tick_rate(20'd1);
    run_random_words(30, 32'd0);
    wait_idle();
    set_tick_rate(20'd0);
    run_random_words(15, 32'd5000);
    wait_idle();
    set_tick_rate(20'd1000000);
    run_random_words(40, 32'hFFFF_F000);
    wait_idle();
    set_tick_rate('1);
    run_random_words(25, 32'h8000_0000);
    wait_idle();
    set_tick_rate($urandom_range(1, 1000000));
    run_random_words(40, $urandom);
    wait_idle();
    set_tick_rate(RATE_W'(RATE_RESET));
    run_random_words(60, 32'd0);
    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    int unsigned drained;
    bit          rx_calm;
    drained = 0;
    rx_calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 7);
      // hold off long enough for the input to back up
      if (drained == 40 || drained == 200) stall = LONG_HOLD;
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      drained++;
    end
  end

  always @(posedge clk) begin
    sleep_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        $error("result word with nothing awaited: id %0d", out_woken_or_queued_id);
        fail_count++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("woken_or_queued_id", want.id, out_woken_or_queued_id);
        check_field("status", want.status, out_status);
        check_field("sleeping_count", want.count, out_sleeping_count);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
